// File: rtl/mmt_pkg.sv
// Shared types, token codes and character-class helpers for the maximal munch tokenizer.
// No dependencies; every other file in rtl/ uses this package.
package mmt_pkg;

    localparam int MAX_COLUMNS_DEF = 4096;
    localparam int OUT_W           = 12;
    localparam int RES_PER_ITEM    = 3;
    localparam int FIFO_DEPTH      = 4;
    localparam int FIFO_AW         = $clog2(FIFO_DEPTH);

    localparam logic [3:0] K_IDENT  = 4'd0;
    localparam logic [3:0] K_NUM    = 4'd1;
    localparam logic [3:0] K_LPAREN = 4'd2;
    localparam logic [3:0] K_RPAREN = 4'd3;
    localparam logic [3:0] K_BEC    = 4'd4;
    localparam logic [3:0] K_EQ     = 4'd5;
    localparam logic [3:0] K_COMMA  = 4'd6;
    localparam logic [3:0] K_PLUS   = 4'd7;
    localparam logic [3:0] K_MINUS  = 4'd8;
    localparam logic [3:0] K_STAR   = 4'd9;
    localparam logic [3:0] K_SLASH  = 4'd10;
    localparam logic [3:0] K_DEF    = 4'd11;
    localparam logic [3:0] K_EXTERN = 4'd12;
    localparam logic [3:0] K_ERROR  = 4'd13;
    localparam logic [3:0] K_EOL    = 4'd14;
    localparam logic [3:0] K_DROP   = 4'd15;

    typedef struct packed {
        logic [7:0] char_code;
        logic       line_end;
    } t_in_req;

    typedef struct packed {
        logic [3:0]       token_kind;
        logic [OUT_W-1:0] start_column;
        logic [OUT_W-1:0] token_length;
        logic             last;
    } t_out_req;

    typedef enum logic [15:0] {
        S_START = 16'h0001,
        S_ID    = 16'h0002,
        S_NUM   = 16'h0004,
        S_ZERO  = 16'h0008,
        S_DOT   = 16'h0010,
        S_FRAC  = 16'h0020,
        S_LP    = 16'h0040,
        S_RP    = 16'h0080,
        S_BEC   = 16'h0100,
        S_EQ    = 16'h0200,
        S_COMMA = 16'h0400,
        S_WS    = 16'h0800,
        S_PLUS  = 16'h1000,
        S_MINUS = 16'h2000,
        S_STAR  = 16'h4000,
        S_SLASH = 16'h8000
    } t_lex_state;

    typedef struct packed {
        logic       fail;
        t_lex_state st;
    } t_trans;

    function automatic logic is_alpha(logic [7:0] c);
        return (c inside {["a":"z"]}) || (c inside {["A":"Z"]});
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return c inside {["0":"9"]};
    endfunction

    function automatic logic is_space(logic [7:0] c);
        return (c == " ") || (c inside {[8'd9:8'd13]});
    endfunction

    function automatic t_trans trans(t_lex_state s, logic [7:0] c);
        t_trans r;
        r.fail = 1'b1;
        r.st   = S_START;
        if (!c[7]) begin
            case (s)
                S_START: begin
                    r.fail = 1'b0;
                    if (is_alpha(c))                  r.st = S_ID;
                    else if (c == "0")                r.st = S_ZERO;
                    else if (is_digit(c))             r.st = S_NUM;
                    else if (c == "(")                r.st = S_LP;
                    else if (c == ")")                r.st = S_RP;
                    else if (c == "=")                r.st = S_BEC;
                    else if (c == "+")                r.st = S_PLUS;
                    else if (c == "-")                r.st = S_MINUS;
                    else if (c == "*")                r.st = S_STAR;
                    else if (c == "/")                r.st = S_SLASH;
                    else if (c == ",")                r.st = S_COMMA;
                    else if (c == "#" || is_space(c)) r.st = S_WS;
                    else                              r.fail = 1'b1;
                end
                S_ID: begin
                    r.fail = !(is_alpha(c) || is_digit(c));
                    r.st   = S_ID;
                end
                S_NUM: begin
                    r.fail = !(is_digit(c) || c == ".");
                    r.st   = is_digit(c) ? S_NUM : S_DOT;
                end
                S_ZERO: begin
                    r.fail = (c != ".");
                    r.st   = S_DOT;
                end
                S_DOT, S_FRAC: begin
                    r.fail = !is_digit(c);
                    r.st   = S_FRAC;
                end
                S_WS: begin
                    r.fail = !is_space(c);
                    r.st   = S_WS;
                end
                S_BEC: begin
                    r.fail = (c != "=");
                    r.st   = S_EQ;
                end
                default: begin
                    r.fail = 1'b1;
                end
            endcase
        end
        return r;
    endfunction

    function automatic logic [3:0] kind_of(t_lex_state s);
        logic [3:0] k;
        case (s)
            S_ID:                k = K_IDENT;
            S_NUM, S_ZERO, S_FRAC: k = K_NUM;
            S_LP:                k = K_LPAREN;
            S_RP:                k = K_RPAREN;
            S_BEC:               k = K_BEC;
            S_EQ:                k = K_EQ;
            S_COMMA:             k = K_COMMA;
            S_PLUS:              k = K_PLUS;
            S_MINUS:             k = K_MINUS;
            S_STAR:              k = K_STAR;
            S_SLASH:             k = K_SLASH;
            default:             k = K_DROP;
        endcase
        return k;
    endfunction

    function automatic logic [3:0] close_kind(t_lex_state s, logic [1:0] kc, logic [31:0] len);
        logic [3:0] k;
        k = kind_of(s);
        if (k == K_IDENT) begin
            if (kc[0] && len == 32'd3) begin
                k = K_DEF;
            end else if (kc[1] && len == 32'd6) begin
                k = K_EXTERN;
            end
        end
        return k;
    endfunction

    function automatic logic kw_def_hit(logic [31:0] p, logic [7:0] c);
        logic hit;
        case (p)
            32'd0:   hit = (c == "d");
            32'd1:   hit = (c == "e");
            32'd2:   hit = (c == "f");
            default: hit = 1'b0;
        endcase
        return hit;
    endfunction

    function automatic logic kw_ext_hit(logic [31:0] p, logic [7:0] c);
        logic hit;
        case (p)
            32'd0:   hit = (c == "e");
            32'd1:   hit = (c == "x");
            32'd2:   hit = (c == "t");
            32'd3:   hit = (c == "e");
            32'd4:   hit = (c == "r");
            32'd5:   hit = (c == "n");
            default: hit = 1'b0;
        endcase
        return hit;
    endfunction

    function automatic logic [OUT_W-1:0] sat_out(logic [31:0] v);
        return (v > 32'((1 << OUT_W) - 1)) ? {OUT_W{1'b1}} : v[OUT_W-1:0];
    endfunction

endpackage

// File: rtl/mmt_lex_core.sv
// Lexer state and one-character step logic: automaton, columns, keyword tracking.
// Produces up to three results per stepped character. Depends on mmt_pkg.
module mmt_lex_core #(
    parameter int MAX_COLUMNS = mmt_pkg::MAX_COLUMNS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  mmt_pkg::t_in_req  i_char,
    output mmt_pkg::t_out_req o_res [mmt_pkg::RES_PER_ITEM],
    output logic [1:0]        o_res_cnt
);

    localparam int CW = $clog2(MAX_COLUMNS);

    mmt_pkg::t_lex_state r_state, n_state;
    logic [CW-1:0]       r_tstart, n_tstart;
    logic [CW-1:0]       r_col, n_col;
    logic [1:0]          r_kc, n_kc;
    logic                r_cmt, n_cmt;
    logic                r_skip, n_skip;

    mmt_pkg::t_trans     v_tr;
    mmt_pkg::t_out_req   v_res [mmt_pkg::RES_PER_ITEM];
    logic [1:0]          v_cnt;
    logic [CW:0]         v_len;
    logic [CW-1:0]       v_pos;
    logic [3:0]          v_k;
    logic [7:0]          c;
    logic                le;

    assign c  = i_char.char_code;
    assign le = i_char.line_end;

    always_comb begin
        n_state  = r_state;
        n_tstart = r_tstart;
        n_col    = r_col;
        n_kc     = r_kc;
        n_cmt    = r_cmt;
        n_skip   = r_skip;
        v_cnt    = 2'd0;
        v_len    = '0;
        v_pos    = '0;
        v_k      = mmt_pkg::K_DROP;
        for (int i = 0; i < mmt_pkg::RES_PER_ITEM; i++) begin
            v_res[i] = '0;
        end
        v_tr = mmt_pkg::trans(r_state, c);

        if (!r_skip) begin
            if (v_tr.fail && r_state != mmt_pkg::S_START) begin
                if (r_state == mmt_pkg::S_DOT) begin
                    v_len = {1'b0, r_col} - {1'b0, r_tstart} + (CW+1)'(1);
                    v_res[v_cnt] = '{mmt_pkg::K_ERROR, mmt_pkg::sat_out(32'(r_tstart)),
                                     mmt_pkg::sat_out(32'(v_len)), 1'b0};
                    v_cnt   = v_cnt + 2'd1;
                    n_skip  = 1'b1;
                    n_state = mmt_pkg::S_START;
                end else begin
                    v_len = {1'b0, r_col} - {1'b0, r_tstart};
                    v_k   = mmt_pkg::close_kind(r_state, r_kc, 32'(v_len));
                    if (v_k != mmt_pkg::K_DROP && !r_cmt) begin
                        v_res[v_cnt] = '{v_k, mmt_pkg::sat_out(32'(r_tstart)),
                                         mmt_pkg::sat_out(32'(v_len)), 1'b0};
                        v_cnt = v_cnt + 2'd1;
                    end
                    n_state = mmt_pkg::S_START;
                    v_tr    = mmt_pkg::trans(mmt_pkg::S_START, c);
                end
            end
            if (!n_skip) begin
                if (v_tr.fail) begin
                    v_res[v_cnt] = '{mmt_pkg::K_ERROR, mmt_pkg::sat_out(32'(r_col)),
                                     mmt_pkg::sat_out(32'd1), 1'b0};
                    v_cnt   = v_cnt + 2'd1;
                    n_skip  = 1'b1;
                    n_state = mmt_pkg::S_START;
                end else begin
                    if (n_state == mmt_pkg::S_START) begin
                        n_tstart = r_col;
                        n_kc     = 2'b11;
                        if (c == "#") begin
                            n_cmt = 1'b1;
                        end
                    end
                    v_pos = r_col - n_tstart;
                    if (!mmt_pkg::kw_def_hit(32'(v_pos), c)) begin
                        n_kc[0] = 1'b0;
                    end
                    if (!mmt_pkg::kw_ext_hit(32'(v_pos), c)) begin
                        n_kc[1] = 1'b0;
                    end
                    n_state = v_tr.st;
                    if (le) begin
                        v_len = {1'b0, r_col} - {1'b0, n_tstart} + (CW+1)'(1);
                        if (n_state == mmt_pkg::S_DOT) begin
                            v_res[v_cnt] = '{mmt_pkg::K_ERROR,
                                             mmt_pkg::sat_out(32'(n_tstart)),
                                             mmt_pkg::sat_out(32'(v_len)), 1'b0};
                            v_cnt = v_cnt + 2'd1;
                        end else begin
                            v_k = mmt_pkg::close_kind(n_state, n_kc, 32'(v_len));
                            if (v_k != mmt_pkg::K_DROP && !n_cmt) begin
                                v_res[v_cnt] = '{v_k, mmt_pkg::sat_out(32'(n_tstart)),
                                                 mmt_pkg::sat_out(32'(v_len)), 1'b0};
                                v_cnt = v_cnt + 2'd1;
                            end
                        end
                        n_state = mmt_pkg::S_START;
                    end
                end
            end
        end

        if (le) begin
            v_res[v_cnt] = '{mmt_pkg::K_EOL, mmt_pkg::sat_out(32'(r_col)),
                             mmt_pkg::sat_out(32'd0), 1'b0};
            v_cnt    = v_cnt + 2'd1;
            n_state  = mmt_pkg::S_START;
            n_tstart = '0;
            n_col    = '0;
            n_kc     = 2'b11;
            n_cmt    = 1'b0;
            n_skip   = 1'b0;
        end else if (r_col < CW'(MAX_COLUMNS - 1)) begin
            n_col = r_col + CW'(1);
        end

        if (v_cnt != 2'd0) begin
            v_res[v_cnt - 2'd1].last = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= mmt_pkg::S_START;
            r_tstart <= '0;
            r_col    <= '0;
            r_kc     <= 2'b11;
            r_cmt    <= 1'b0;
            r_skip   <= 1'b0;
        end else if (i_step) begin
            r_state  <= n_state;
            r_tstart <= n_tstart;
            r_col    <= n_col;
            r_kc     <= n_kc;
            r_cmt    <= n_cmt;
            r_skip   <= n_skip;
        end
    end

    assign o_res     = v_res;
    assign o_res_cnt = v_cnt;

endmodule

// File: rtl/mmt_res_fifo.sv
// Result queue: takes up to three results per cycle, hands out one per request.
// Depends on mmt_pkg.
module mmt_res_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mmt_pkg::t_out_req i_push_data [mmt_pkg::RES_PER_ITEM],
    input  logic [1:0]        i_push_cnt,
    output logic              o_room,
    output logic              o_valid,
    input  logic              i_ready,
    output mmt_pkg::t_out_req o_data
);

    localparam int AW = mmt_pkg::FIFO_AW;

    mmt_pkg::t_out_req r_mem [mmt_pkg::FIFO_DEPTH];
    logic [AW-1:0]     r_wptr, n_wptr;
    logic [AW-1:0]     r_rptr, n_rptr;
    logic [AW:0]       r_count, n_count;
    logic              pop;

    assign pop     = o_valid && i_ready;
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rptr];
    assign o_room  = (r_count <= (AW+1)'(mmt_pkg::FIFO_DEPTH - mmt_pkg::RES_PER_ITEM));

    always_comb begin
        n_wptr  = r_wptr + AW'(i_push_cnt);
        n_rptr  = r_rptr + AW'(pop);
        n_count = r_count + (AW+1)'(i_push_cnt) - (AW+1)'(pop);
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < mmt_pkg::RES_PER_ITEM; k++) begin
            if (2'(k) < i_push_cnt) begin
                r_mem[r_wptr + AW'(k)] <= i_push_data[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

endmodule

// File: rtl/maximal_munch_tokenizer.sv
// Top level of the maximal munch tokenizer: input register, lexer core and result queue.
// Depends on mmt_pkg, mmt_lex_core and mmt_res_fifo.
//
// Usage: one character per request enters on i_req (char_code, line_end) under
// i_req_valid/o_req_ready. Tokens leave on o_res (token_kind, start_column,
// token_length, last) under o_res_valid/i_res_ready, one per request, with last set
// on the final result caused by a character. Whitespace gives no result; every line
// closes with an end-of-line result.
// A character is registered on acceptance and then stepped through the lexer, which
// writes its results to a four-entry queue; o_res shows the head of that queue. The
// block takes one character per cycle as long as the receiver drains results as fast
// as they appear; a character that produces several results hands them out one after
// another. The lexer steps only when the queue has room for three results, so a
// stalled receiver fills the queue and then holds o_req_ready low without losing
// anything.
// Reset (synchronous, active low) empties the queue and the input register and puts
// the lexer at the start of a line with column zero.
module maximal_munch_tokenizer #(
    parameter int MAX_COLUMNS = mmt_pkg::MAX_COLUMNS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    output logic              o_req_ready,
    input  mmt_pkg::t_in_req  i_req,
    output logic              o_res_valid,
    input  logic              i_res_ready,
    output mmt_pkg::t_out_req o_res
);

    logic              r_in_vld;
    mmt_pkg::t_in_req  r_in;
    logic              step;
    logic              room;
    mmt_pkg::t_out_req core_res [mmt_pkg::RES_PER_ITEM];
    logic [1:0]        core_cnt;
    logic [1:0]        push_cnt;

    assign step        = r_in_vld && room;
    assign o_req_ready = !r_in_vld || step;
    assign push_cnt    = step ? core_cnt : 2'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_req_ready) begin
            r_in_vld <= i_req_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req_valid && o_req_ready) begin
            r_in <= i_req;
        end
    end

    mmt_lex_core #(
        .MAX_COLUMNS(MAX_COLUMNS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_char   (r_in),
        .o_res    (core_res),
        .o_res_cnt(core_cnt)
    );

    mmt_res_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_data(core_res),
        .i_push_cnt (push_cnt),
        .o_room     (room),
        .o_valid    (o_res_valid),
        .i_ready    (i_res_ready),
        .o_data     (o_res)
    );

endmodule

// File: bench/mmt_token_check.sv
`timescale 1ns / 1ps
// Token checker for the maximal munch tokenizer: watches both request channels, lexes
// every accepted character on its own and compares the block's tokens in order.
// Depends on mmt_pkg for the request types, token kinds and lexer state names.
module mmt_token_check #(
    parameter int MAX_COLUMNS = mmt_pkg::MAX_COLUMNS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    input  logic              i_req_ready,
    input  mmt_pkg::t_in_req  i_req,
    input  logic              i_res_valid,
    input  logic              i_res_ready,
    input  mmt_pkg::t_out_req i_res,
    output int                o_fail_count,
    output int                o_pending,
    output int                o_checked
);

    mmt_pkg::t_out_req   token_q[$];
    mmt_pkg::t_lex_state lex_st;
    int                  tok_col;
    int                  col_now;
    int                  mismatches;
    int                  checked;
    logic [1:0]          kw_live;
    logic                in_comment;
    logic                skip_rest;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
        mismatches   = 0;
        checked      = 0;
    end

    function automatic mmt_pkg::t_lex_state advance(input mmt_pkg::t_lex_state s,
                                                    input logic [7:0] c,
                                                    output logic ok);
        logic                alpha;
        logic                digit;
        logic                space;
        mmt_pkg::t_lex_state nxt;
        alpha = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
        digit = (c >= "0" && c <= "9");
        space = (c == " ") || (c >= 8'd9 && c <= 8'd13);
        nxt   = mmt_pkg::S_START;
        ok    = 1'b1;
        if (c[7]) begin
            ok = 1'b0;
        end else begin
            case (s)
                mmt_pkg::S_START: begin
                    if (alpha) nxt = mmt_pkg::S_ID;
                    else if (c == "0") nxt = mmt_pkg::S_ZERO;
                    else if (digit) nxt = mmt_pkg::S_NUM;
                    else if (c == "(") nxt = mmt_pkg::S_LP;
                    else if (c == ")") nxt = mmt_pkg::S_RP;
                    else if (c == "=") nxt = mmt_pkg::S_BEC;
                    else if (c == "+") nxt = mmt_pkg::S_PLUS;
                    else if (c == "-") nxt = mmt_pkg::S_MINUS;
                    else if (c == "*") nxt = mmt_pkg::S_STAR;
                    else if (c == "/") nxt = mmt_pkg::S_SLASH;
                    else if (c == ",") nxt = mmt_pkg::S_COMMA;
                    else if (c == "#" || space) nxt = mmt_pkg::S_WS;
                    else ok = 1'b0;
                end
                mmt_pkg::S_ID: begin
                    if (alpha || digit) nxt = mmt_pkg::S_ID;
                    else ok = 1'b0;
                end
                mmt_pkg::S_NUM: begin
                    if (digit) nxt = mmt_pkg::S_NUM;
                    else if (c == ".") nxt = mmt_pkg::S_DOT;
                    else ok = 1'b0;
                end
                mmt_pkg::S_ZERO: begin
                    if (c == ".") nxt = mmt_pkg::S_DOT;
                    else ok = 1'b0;
                end
                mmt_pkg::S_DOT, mmt_pkg::S_FRAC: begin
                    if (digit) nxt = mmt_pkg::S_FRAC;
                    else ok = 1'b0;
                end
                mmt_pkg::S_WS: begin
                    if (space) nxt = mmt_pkg::S_WS;
                    else ok = 1'b0;
                end
                mmt_pkg::S_BEC: begin
                    if (c == "=") nxt = mmt_pkg::S_EQ;
                    else ok = 1'b0;
                end
                default: begin
                    ok = 1'b0;
                end
            endcase
        end
        return nxt;
    endfunction

    function automatic logic [3:0] token_kind_for(input mmt_pkg::t_lex_state s);
        case (s)
            mmt_pkg::S_ID:                                    return mmt_pkg::K_IDENT;
            mmt_pkg::S_NUM, mmt_pkg::S_ZERO, mmt_pkg::S_FRAC: return mmt_pkg::K_NUM;
            mmt_pkg::S_LP:                                    return mmt_pkg::K_LPAREN;
            mmt_pkg::S_RP:                                    return mmt_pkg::K_RPAREN;
            mmt_pkg::S_BEC:                                   return mmt_pkg::K_BEC;
            mmt_pkg::S_EQ:                                    return mmt_pkg::K_EQ;
            mmt_pkg::S_COMMA:                                 return mmt_pkg::K_COMMA;
            mmt_pkg::S_PLUS:                                  return mmt_pkg::K_PLUS;
            mmt_pkg::S_MINUS:                                 return mmt_pkg::K_MINUS;
            mmt_pkg::S_STAR:                                  return mmt_pkg::K_STAR;
            mmt_pkg::S_SLASH:                                 return mmt_pkg::K_SLASH;
            default:                                          return mmt_pkg::K_DROP;
        endcase
    endfunction

    function automatic logic kw_match(input string w, input int p, input logic [7:0] c);
        return (p < w.len()) && (w[p] == c);
    endfunction

    function automatic logic [mmt_pkg::OUT_W-1:0] clip(input int v);
        return (v > (1 << mmt_pkg::OUT_W) - 1) ? {mmt_pkg::OUT_W{1'b1}}
                                               : v[mmt_pkg::OUT_W-1:0];
    endfunction

    task automatic push_token(input logic [3:0] k, input int start, input int len);
        mmt_pkg::t_out_req t;
        t.token_kind   = k;
        t.start_column = clip(start);
        t.token_length = clip(len);
        t.last         = 1'b0;
        token_q.insert(token_q.size(), t);
    endtask

    task automatic close_token(input int len);
        logic [3:0] k;
        k      = token_kind_for(lex_st);
        lex_st = mmt_pkg::S_START;
        if (k == mmt_pkg::K_IDENT && kw_live[0] && len == 3) k = mmt_pkg::K_DEF;
        else if (k == mmt_pkg::K_IDENT && kw_live[1] && len == 6) k = mmt_pkg::K_EXTERN;
        if (k != mmt_pkg::K_DROP && !in_comment) push_token(k, tok_col, len);
    endtask

    task automatic take_char(input logic [7:0] c, input int col,
                             input mmt_pkg::t_lex_state ns);
        if (lex_st == mmt_pkg::S_START) begin
            tok_col = col;
            kw_live = 2'b11;
            if (c == "#") in_comment = 1'b1;
        end
        if (!kw_match("def", col - tok_col, c)) kw_live[0] = 1'b0;
        if (!kw_match("extern", col - tok_col, c)) kw_live[1] = 1'b0;
        lex_st = ns;
    endtask

    task automatic reset_line();
        lex_st     = mmt_pkg::S_START;
        tok_col    = 0;
        col_now    = 0;
        kw_live    = 2'b11;
        in_comment = 1'b0;
        skip_rest  = 1'b0;
    endtask

    task automatic tokenize_char(input logic [7:0] c, input logic le);
        int                  col;
        int                  n0;
        logic                ok;
        mmt_pkg::t_lex_state ns;
        mmt_pkg::t_out_req   tail;
        col = col_now;
        n0  = token_q.size();
        if (!skip_rest) begin
            ns = advance(lex_st, c, ok);
            if (!ok && lex_st != mmt_pkg::S_START) begin
                if (lex_st == mmt_pkg::S_DOT) begin
                    push_token(mmt_pkg::K_ERROR, tok_col, col - tok_col + 1);
                    skip_rest = 1'b1;
                    lex_st    = mmt_pkg::S_START;
                end else begin
                    close_token(col - tok_col);
                    ns = advance(mmt_pkg::S_START, c, ok);
                end
            end
            if (!skip_rest) begin
                if (!ok) begin
                    push_token(mmt_pkg::K_ERROR, col, 1);
                    skip_rest = 1'b1;
                    lex_st    = mmt_pkg::S_START;
                end else begin
                    take_char(c, col, ns);
                    if (le) begin
                        if (lex_st == mmt_pkg::S_DOT) begin
                            push_token(mmt_pkg::K_ERROR, tok_col, col - tok_col + 1);
                            lex_st = mmt_pkg::S_START;
                        end else begin
                            close_token(col - tok_col + 1);
                        end
                    end
                end
            end
        end
        if (le) begin
            push_token(mmt_pkg::K_EOL, col, 0);
            reset_line();
        end else if (col_now < MAX_COLUMNS - 1) begin
            col_now = col_now + 1;
        end
        if (token_q.size() > n0) begin
            tail                        = token_q[token_q.size() - 1];
            tail.last                   = 1'b1;
            token_q[token_q.size() - 1] = tail;
        end
    endtask

    task automatic check_token(input mmt_pkg::t_out_req got);
        mmt_pkg::t_out_req want;
        checked = checked + 1;
        if (token_q.size() == 0) begin
            if (mismatches < 10)
                $display("unexpected token: kind %0d col %0d len %0d last %0b",
                         got.token_kind, got.start_column, got.token_length, got.last);
            mismatches = mismatches + 1;
        end else begin
            want = token_q.pop_front();
            if (got.token_kind !== want.token_kind || got.start_column !== want.start_column ||
                got.token_length !== want.token_length || got.last !== want.last) begin
                if (mismatches < 10)
                    $display({"token mismatch: want kind %0d col %0d len %0d last %0b, ",
                              "got kind %0d col %0d len %0d last %0b"},
                             want.token_kind, want.start_column, want.token_length, want.last,
                             got.token_kind, got.start_column, got.token_length, got.last);
                mismatches = mismatches + 1;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            token_q.delete();
            reset_line();
        end else begin
            if (i_req_valid && i_req_ready) tokenize_char(i_req.char_code, i_req.line_end);
            if (i_res_valid && i_res_ready) check_token(i_res);
        end
        o_pending    <= token_q.size();
        o_fail_count <= mismatches;
        o_checked    <= checked;
    end

endmodule

// File: bench/tb_maximal_munch_tokenizer.sv
`timescale 1ns / 1ps
// Top of the tokenizer testbench: clock, reset, character requests and a stalling
// token receiver around the block, with mmt_token_check doing the checking.
// Depends on mmt_pkg, maximal_munch_tokenizer and mmt_token_check.
module tb_maximal_munch_tokenizer;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_CHARS   = 450;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_req_valid = 1'b0;
    logic              i_res_ready = 1'b0;
    mmt_pkg::t_in_req  req_bus     = '0;
    logic              o_req_ready;
    logic              o_res_valid;
    mmt_pkg::t_out_req res_bus;

    int         fail_count;
    int         pending;
    int         checked;
    int         idle_cycles = 0;
    int         chars_sent  = 0;
    int         lines_sent  = 0;
    int         tokens_seen = 0;
    bit         src_burst   = 1'b0;
    bit         snk_burst   = 1'b0;
    logic [7:0] char_q[$];

    maximal_munch_tokenizer i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_req       (req_bus),
        .o_res_valid (o_res_valid),
        .i_res_ready (i_res_ready),
        .o_res       (res_bus)
    );

    mmt_token_check u_token_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (i_req_valid),
        .i_req_ready  (o_req_ready),
        .i_req        (req_bus),
        .i_res_valid  (o_res_valid),
        .i_res_ready  (i_res_ready),
        .i_res        (res_bus),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_req_valid && o_req_ready) || (o_res_valid && i_res_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("maximal_munch_tokenizer verification failed");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    task automatic send_char(input logic [7:0] c, input logic le);
        int gap;
        gap = src_burst ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            i_req_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_req_valid <= 1'b1;
        req_bus     <= '{char_code: c, line_end: le};
        do @(posedge i_clk); while (!o_req_ready);
        chars_sent = chars_sent + 1;
        if (le) lines_sent = lines_sent + 1;
        if (chars_sent % 32 == 0) src_burst = ($urandom_range(0, 3) == 0);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
    endtask

    task automatic put_char(input logic [7:0] c);
        char_q.insert(char_q.size(), c);
    endtask

    task automatic append_text(input string s);
        for (int i = 0; i < s.len(); i++) put_char(s[i]);
    endtask

    function automatic logic [7:0] rand_letter();
        return $urandom_range(0, 1) ? 8'($urandom_range(97, 122)) : 8'($urandom_range(65, 90));
    endfunction

    function automatic logic [7:0] rand_alnum();
        return $urandom_range(0, 2) == 0 ? 8'($urandom_range(48, 57)) : rand_letter();
    endfunction

    task automatic add_token();
        int pick;
        int v;
        pick = $urandom_range(0, 29);
        if (pick < 8) begin
            put_char(rand_letter());
            repeat ($urandom_range(0, 5)) put_char(rand_alnum());
        end else if (pick < 14) begin
            if ($urandom_range(0, 3) == 0) begin
                put_char("0");
            end else begin
                repeat ($urandom_range(1, 4)) put_char(8'($urandom_range(48, 57)));
            end
            if ($urandom_range(0, 2) == 0) begin
                put_char(".");
                repeat ($urandom_range(1, 3)) put_char(8'($urandom_range(48, 57)));
            end
        end else if (pick < 18) begin
            case ($urandom_range(0, 6))
                0:       put_char("(");
                1:       put_char(")");
                2:       put_char(",");
                3:       put_char("+");
                4:       put_char("-");
                5:       put_char("*");
                default: put_char("/");
            endcase
        end else if (pick < 20) begin
            append_text($urandom_range(0, 1) ? "==" : "=");
        end else if (pick < 23) begin
            repeat ($urandom_range(1, 3)) begin
                v = $urandom_range(8, 13);
                put_char(v == 8 ? " " : 8'(v));
            end
        end else if (pick < 24) begin
            put_char("#");
            repeat ($urandom_range(0, 4)) put_char(8'($urandom_range(32, 126)));
        end else if (pick < 28) begin
            case ($urandom_range(0, 6))
                0:       append_text("def");
                1:       append_text("extern");
                2:       append_text("de");
                3:       append_text("defs");
                4:       append_text("extrn");
                5:       append_text("externa");
                default: append_text("Def");
            endcase
        end else if ($urandom_range(0, 1)) begin
            put_char(8'($urandom_range(0, 255)));
        end else begin
            put_char(8'($urandom_range(48, 57)));
            put_char(".");
        end
    endtask

    initial begin
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            int gap;
            gap = snk_burst ? 0 : $urandom_range(0, 9);
            if (gap > 0) begin
                i_res_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_res_ready <= 1'b1;
            do @(posedge i_clk); while (!o_res_valid);
            tokens_seen = tokens_seen + 1;
            if (tokens_seen % 32 == 0) snk_burst = ($urandom_range(0, 3) == 0);
        end
    end

    initial begin
        int random_chars;
        random_chars = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_text("extern(def,0");
        send_text("=a==9.5+-*/)");
        send_text("3.)x");
        send_text("#y");
        send_char(8'hFF, 1'b1);
        send_char(8'h00, 1'b0);
        send_text("5.");

        while (random_chars < RANDOM_CHARS) begin
            char_q.delete();
            repeat ($urandom_range(1, 8)) begin
                add_token();
                if ($urandom_range(0, 1)) put_char(" ");
            end
            for (int i = 0; i < char_q.size(); i++) send_char(char_q[i], i == char_q.size() - 1);
            random_chars = random_chars + char_q.size();
        end
        i_req_valid <= 1'b0;

        do @(posedge i_clk); while (pending != 0);
        repeat (16) @(posedge i_clk);

        $display("Sent %0d characters on %0d lines of mixed tokens, errors and comments.",
                 chars_sent, lines_sent);
        $display("Compared %0d tokens against the predicted stream, %0d mismatched.",
                 checked, fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("maximal_munch_tokenizer verification clean");
        end else begin
            $display("maximal_munch_tokenizer verification failed");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/mmt_pkg.sv
rtl/mmt_lex_core.sv
rtl/mmt_res_fifo.sv
rtl/maximal_munch_tokenizer.sv
bench/mmt_token_check.sv
bench/tb_maximal_munch_tokenizer.sv
